FILE: design/sha256_stream_hash_assert.svh
// ---------------------------------------------------------------------------
// sha256_stream_hash_assert.svh
// assertion macros shared by the checker of the hash block
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg
// constants, tables and controller/datapath interface types of the hash block
// ---------------------------------------------------------------------------
package shs_pkg;

  localparam int BLOCK_BITS   = 512;
  localparam int WORD_BITS    = 32;
  localparam int DIGEST_WORDS = 8;
  localparam int ROUNDS       = 64;
  localparam int FILL_BITS    = 6;
  localparam int COUNT_BITS   = 61;
  localparam int ROUND_BITS   = 6;
  localparam int INDEX_BITS   = 3;

  localparam logic [7:0] PAD_MARK = 8'h80;
  // the length field starts at byte position 56 of the closing block
  localparam logic [2:0] LEN_FIELD_HI = 3'b111;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // commands from the controller to the datapath
  typedef struct packed {
    logic                  shift_byte;  // take the input byte into the block
    logic                  shift_pad;   // take one padding byte into the block
    logic                  pad_first;   // padding byte is the 0x80 mark
    logic                  len_phase;   // length field belongs to this block
    logic                  load_v;      // working vars from chain words
    logic                  round;       // one compression round
    logic [ROUND_BITS-1:0] round_idx;
    logic                  add_chain;   // fold working vars into chain
    logic                  load_out;    // digest to output buffer, restart
    logic                  shift_out;   // next digest word to the port
  } shs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [FILL_BITS-1:0] fill;
    logic                 fill_last;    // next byte completes the block
  } shs_stat_t;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WORD_BITS - n));
  endfunction

endpackage

FILE: design/shs_ctrl.sv
// ---------------------------------------------------------------------------
// shs_ctrl
// sequencer: byte intake, padding, compression rounds and digest handoff
// ---------------------------------------------------------------------------
module shs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_byte_present,
  input  logic                          in_last_byte,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [shs_pkg::INDEX_BITS-1:0] out_word_index,
  output logic                          out_last_word,
  input  shs_pkg::shs_stat_t            stat,
  output shs_pkg::shs_cmd_t             cmd
);
  import shs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOADV = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(ROUNDS - 1);
  localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(DIGEST_WORDS - 1);

  state_t                state_r, state_nxt;
  logic [ROUND_BITS-1:0] rnd_r, rnd_nxt;
  logic                  pend_r, pend_nxt;     // closing in progress
  logic                  first_r, first_nxt;   // 0x80 mark still due
  logic                  len_ok_r, len_ok_nxt; // current block takes the length
  logic                  final_r, final_nxt;   // running the closing block
  logic                  oval_r, oval_nxt;
  logic [INDEX_BITS-1:0] oidx_r, oidx_nxt;
  logic                  in_acc;
  logic                  out_acc;

  assign in_ready       = (state_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = oval_r;
  assign out_word_index = oidx_r;
  assign out_last_word  = (oidx_r == LAST_INDEX);
  assign out_acc        = oval_r && out_ready;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    len_ok_nxt    = len_ok_r;
    final_nxt     = final_r;
    oval_nxt      = oval_r;
    oidx_nxt      = oidx_r;
    cmd           = '0;
    cmd.round_idx = rnd_r;
    cmd.pad_first = first_r;
    cmd.len_phase = len_ok_r;

    if (out_acc) begin
      cmd.shift_out = 1'b1;
      oidx_nxt      = oidx_r + 1'b1;
      if (oidx_r == LAST_INDEX) begin
        oval_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.shift_byte = in_byte_present;
          if (in_last_byte) begin
            pend_nxt   = 1'b1;
            first_nxt  = 1'b1;
            len_ok_nxt = 1'b0;
            final_nxt  = 1'b0;
          end
          if (in_byte_present && stat.fill_last) begin
            state_nxt = S_LOADV;
          end else if (in_last_byte) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_pad = 1'b1;
        first_nxt     = 1'b0;
        if (first_r && (stat.fill[FILL_BITS-1 -: 3] != LEN_FIELD_HI)) begin
          len_ok_nxt = 1'b1;
        end
        if (stat.fill_last) begin
          final_nxt = len_ok_r;
          state_nxt = S_LOADV;
        end
      end
      S_LOADV: begin
        cmd.load_v = 1'b1;
        rnd_nxt    = '0;
        state_nxt  = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        if (final_r) begin
          state_nxt = S_DONE;
        end else if (pend_r) begin
          len_ok_nxt = 1'b1;
          state_nxt  = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (!oval_r) begin
          cmd.load_out = 1'b1;
          pend_nxt     = 1'b0;
          final_nxt    = 1'b0;
          oval_nxt     = 1'b1;
          oidx_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rnd_r    <= '0;
      pend_r   <= 1'b0;
      first_r  <= 1'b0;
      len_ok_r <= 1'b0;
      final_r  <= 1'b0;
      oval_r   <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      len_ok_r <= len_ok_nxt;
      final_r  <= final_nxt;
      oval_r   <= oval_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

endmodule

FILE: design/shs_dp.sv
// ---------------------------------------------------------------------------
// shs_dp
// block window, message schedule, round unit, chain words and digest buffer
// ---------------------------------------------------------------------------
module shs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_data_byte,
  input  shs_pkg::shs_cmd_t  cmd,
  output shs_pkg::shs_stat_t stat,
  output shs_pkg::word_t     out_digest_word
);
  import shs_pkg::*;

  // block bytes shift in at the bottom; during rounds the top word is w[t]
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [FILL_BITS-1:0]  fill_r;
  logic [COUNT_BITS-1:0] count_r;
  word_t                 chain_r [DIGEST_WORDS];
  word_t                 v_r     [DIGEST_WORDS];
  word_t                 dig_r   [DIGEST_WORDS];

  word_t                 w0, w1, w9, w14, w_new;
  word_t                 s0, s1, big0, big1, ch, maj, t1, t2;
  logic [63:0]           len_bits;
  logic [7:0]            pad_byte;

  assign stat.fill      = fill_r;
  assign stat.fill_last = (fill_r == {FILL_BITS{1'b1}});
  assign out_digest_word = dig_r[0];

  // padding byte: mark, zeros, or big-endian bit length in the last eight
  assign len_bits = {count_r, 3'b000};
  always_comb begin
    if (cmd.pad_first) begin
      pad_byte = PAD_MARK;
    end else if (cmd.len_phase && (fill_r[FILL_BITS-1 -: 3] == LEN_FIELD_HI)) begin
      pad_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // message schedule
  assign w0    = blk_r[BLOCK_BITS-1 -: WORD_BITS];
  assign w1    = blk_r[BLOCK_BITS-1*WORD_BITS-1 -: WORD_BITS];
  assign w9    = blk_r[BLOCK_BITS-9*WORD_BITS-1 -: WORD_BITS];
  assign w14   = blk_r[BLOCK_BITS-14*WORD_BITS-1 -: WORD_BITS];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  // round function
  assign big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + ch + ROUND_K[cmd.round_idx] + w0;
  assign big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = big0 + maj;

  always_comb begin
    blk_nxt = blk_r;
    if (cmd.shift_byte) begin
      blk_nxt = {blk_r[BLOCK_BITS-9:0], in_data_byte};
    end else if (cmd.shift_pad) begin
      blk_nxt = {blk_r[BLOCK_BITS-9:0], pad_byte};
    end else if (cmd.round) begin
      blk_nxt = {blk_r[BLOCK_BITS-WORD_BITS-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (cmd.load_v) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
    if (cmd.load_out) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= INIT_HASH[i];
      end
    end else begin
      if (cmd.load_out) begin
        fill_r  <= '0;
        count_r <= '0;
      end else begin
        if (cmd.shift_byte || cmd.shift_pad) begin
          fill_r <= fill_r + 1'b1;
        end
        if (cmd.shift_byte) begin
          count_r <= count_r + 1'b1;
        end
      end
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        if (cmd.load_out) begin
          chain_r[i] <= INIT_HASH[i];
        end else if (cmd.add_chain) begin
          chain_r[i] <= chain_r[i] + v_r[i];
        end
      end
    end
  end

endmodule

FILE: design/sha256_stream_hash.sv
// ---------------------------------------------------------------------------
// sha256_stream_hash
// streaming sha-256: message bytes in, eight-word digest out
// ---------------------------------------------------------------------------
// input channel: one word per handshake carries a byte (in_data_byte, valid
//   when in_byte_present) and an end-of-message flag (in_last_byte); a word
//   with no byte and the end flag closes a message, empty messages included
// output channel: eight words per message, digest word 0 first, with
//   out_word_index 0..7 and out_last_word on the eighth
// intake: each 64th byte starts a compression (load, 64 rounds on the
//   single round unit, chain add), and no input is taken until it is done
// closing: one padding byte per cycle up to the block end, one or two
//   compressions, then the digest moves to the output buffer and the chain
//   reloads the initial hash values
// in_ready is high only while the sequencer is idle
// output stall: the digest sits in its own buffer, so the next message is
//   taken while words drain; a second digest waits until the buffer is empty
// reset: synchronous, active low; clears fill, byte count and all control,
//   loads the initial hash values; no clearing pass is needed
// ---------------------------------------------------------------------------
module sha256_stream_hash (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_byte_present,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_digest_word,
  output logic [shs_pkg::INDEX_BITS-1:0] out_word_index,
  output logic                           out_last_word
);
  import shs_pkg::*;

  // control and status between sequencer and datapath
  shs_cmd_t  cmd;
  shs_stat_t stat;

  // sequencer: intake, padding steps, round counter, output handshake
  shs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .in_ready        (in_ready),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .stat            (stat),
    .cmd             (cmd)
  );

  // datapath: block window doubles as the message schedule
  shs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_digest_word (out_digest_word)
  );

endmodule

FILE: design/shs_check.sv
// ---------------------------------------------------------------------------
// shs_check
// port-level checks of the digest output sequence
// ---------------------------------------------------------------------------
`include "sha256_stream_hash_assert.svh"

module shs_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  `SHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_digest_word) && $stable(out_word_index),
    "stalled digest word changed")

  `SHS_ASSERT_NOW(a_last_flag, clk, rst_n, out_valid,
    out_last_word == (out_word_index == 3'd7), "last word flag off index 7")

  `SHS_ASSERT_NOW(a_start_zero, clk, rst_n, $rose(out_valid),
    out_word_index == 3'd0, "digest does not start at word 0")

  `SHS_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && out_ready && !out_last_word,
    out_valid && (out_word_index == $past(out_word_index) + 3'd1),
    "digest words not consecutive")

endmodule

bind sha256_stream_hash shs_check u_shs_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// sha256_stream_hash: message bytes go in with a bursty sender and the
// digest words drain through a stalling receiver; a sha-256 model in the
// bench computes every digest and the words are checked as they come out
// ---------------------------------------------------------------------------
module testbench;
  import shs_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int RST_CYCLES = 5;
  localparam int CYCLE_CAP  = 200000;  // far beyond the slowest correct run
  localparam int DRAIN_WAIT = 300;     // two compressions plus padding, rounded up
  localparam int MIN_ITEMS  = 120;
  localparam int MIN_MSGS   = 6;
  localparam int MAX_REPORT = 60;

  typedef struct {
    word_t                 value;
    logic [INDEX_BITS-1:0] index;
    logic                  final_word;
  } digest_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  in_byte_present = 1'b0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_digest_word;
  logic [INDEX_BITS-1:0] out_word_index;
  logic                  out_last_word;

  sha256_stream_hash DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_byte_present(in_byte_present),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // bench copy of the hash state
  // ------------------------------------------------------------------------
  word_t        hash_chain [DIGEST_WORDS];
  logic [7:0]   msg_block [64];
  int           block_fill;
  logic [60:0]  msg_length;      // bytes so far, wraps like the block's counter
  digest_word_t digests_due [$]; // digest words still owed by the block
  int           fail_count = 0;
  int           cycle_count = 0;

  function automatic word_t rot_right(input word_t x, input int n);
    return (x >> n) | (x << (WORD_BITS - n));
  endfunction

  task automatic hash_restart();
    int i;
    for (i = 0; i < DIGEST_WORDS; i++) hash_chain[i] = INIT_HASH[i];
    block_fill = 0;
    msg_length = '0;
  endtask

  // one 64-round compression of msg_block into hash_chain
  task automatic hash_compress();
    word_t sched [ROUNDS];
    word_t wv [DIGEST_WORDS];
    word_t s0, s1, t1, t2, ch, maj;
    int i;
    for (i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (i = 16; i < ROUNDS; i++) begin
      s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (i = 0; i < DIGEST_WORDS; i++) wv[i] = hash_chain[i];
    for (i = 0; i < ROUNDS; i++) begin
      s1  = rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25);
      ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
      t1  = wv[7] + s1 + ch + ROUND_K[i] + sched[i];
      s0  = rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22);
      maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
      t2  = s0 + maj;
      wv[7] = wv[6];
      wv[6] = wv[5];
      wv[5] = wv[4];
      wv[4] = wv[3] + t1;
      wv[3] = wv[2];
      wv[2] = wv[1];
      wv[1] = wv[0];
      wv[0] = t1 + t2;
    end
    for (i = 0; i < DIGEST_WORDS; i++) hash_chain[i] += wv[i];
  endtask

  // advance the bench state by one input word, queue any digest it causes
  task automatic hash_absorb(input logic [7:0] data, input logic present, input logic last);
    logic [63:0]  bit_len;
    digest_word_t dw;
    int i;
    if (present) begin
      msg_block[block_fill] = data;
      block_fill++;
      msg_length++;
      if (block_fill == 64) begin
        hash_compress();
        block_fill = 0;
      end
    end
    if (last) begin
      bit_len = {msg_length, 3'b000};
      msg_block[block_fill] = PAD_MARK;
      block_fill++;
      // no room left for the length field: pad out and spill to a second block
      if (block_fill > 56) begin
        for (i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
        hash_compress();
        block_fill = 0;
      end
      for (i = block_fill; i < 56; i++) msg_block[i] = 8'h00;
      for (i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
      hash_compress();
      for (i = 0; i < DIGEST_WORDS; i++) begin
        dw.value      = hash_chain[i];
        dw.index      = INDEX_BITS'(i);
        dw.final_word = (i == DIGEST_WORDS - 1);
        digests_due.push_back(dw);
      end
      hash_restart();
    end
  endtask

  // ------------------------------------------------------------------------
  // sender: bursts of words with random gaps in between
  // ------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_word(input logic [7:0] data, input logic present, input logic last);
    int gap;
    if (burst_left == 0) begin
      // about a third of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_byte_present <= present;
    in_last_byte    <= last;
    hash_absorb(data, present, last);
    // the word is taken at the first edge that sees ready
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // a whole message; noisy sprinkles words that carry neither byte nor end
  task automatic send_message(input int len, input bit close_on_byte, input bit noisy);
    int i;
    for (i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    // an empty message can only close with a byteless word
    if (!close_on_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // ------------------------------------------------------------------------
  // receiver: runs of full speed, random ready and hard stalls
  // ------------------------------------------------------------------------
  int rx_mode = 0;
  int rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 2) ? $urandom_range(1, 25) : $urandom_range(10, 50);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= 1'b0;
    endcase
  end

  // ------------------------------------------------------------------------
  // digest checker: every accepted word against the oldest one owed
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_word_t dw;
    if (rst_n && out_valid && out_ready) begin
      if (digests_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORT)
          $display("%0t: digest word with none owed: actual word %h index %0d last %b",
                   $time, out_digest_word, out_word_index, out_last_word);
      end else begin
        dw = digests_due.pop_front();
        if (out_digest_word !== dw.value) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("%0t: digest word mismatch: expected %h actual %h",
                     $time, dw.value, out_digest_word);
        end
        if (out_word_index !== dw.index) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("%0t: word index mismatch: expected %0d actual %0d",
                     $time, dw.index, out_word_index);
        end
        if (out_last_word !== dw.final_word) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("%0t: last word flag mismatch: expected %b actual %b",
                     $time, dw.final_word, out_last_word);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout with %0d digest words owed", $time, digests_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // nothing buffered, one byteless closing word
  task automatic test_empty_message();
    send_word(8'hc3, 1'b0, 1'b1);
  endtask

  // byte extremes, the classic three-byte message closed by a byteless word,
  // and a one-byte message closed on its own byte
  task automatic test_short_messages();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b1);
  endtask

  // words with neither byte nor end flag must leave the state alone
  task automatic test_idle_words();
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h5a, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h7e, 1'b0, 1'b0);
    send_word(8'ha5, 1'b1, 1'b0);
    send_word(8'h81, 1'b0, 1'b0);
    send_word(8'h3c, 1'b1, 1'b1);
  endtask

  // random messages; a share sit on the padding and block boundaries:
  // 55 bytes just fits the length, 56 spills padding into a second block,
  // 63 leaves one pad byte, 64 closing on its byte fills a block first
  task automatic test_random_messages();
    int edge_lens [4] = '{55, 56, 63, 64};
    int sent, msgs, len;
    bit on_byte;
    sent = 0;
    msgs = 0;
    while (sent < MIN_ITEMS || msgs < MIN_MSGS) begin
      if ($urandom_range(0, 9) < 3) len = edge_lens[$urandom_range(0, 3)] + $urandom_range(0, 1);
      else len = $urandom_range(0, 12);
      on_byte = 1'($urandom);
      send_message(len, on_byte, 1'b1);
      sent += len + ((!on_byte || len == 0) ? 1 : 0);
      msgs++;
    end
  endtask

  initial begin
    hash_restart();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_short_messages();
    test_idle_words();
    test_random_messages();

    in_valid <= 1'b0;
    while (digests_due.size() != 0) @(posedge clk);
    // give a stray digest time to show up
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/shs_pkg.sv
design/shs_ctrl.sv
design/shs_dp.sv
design/sha256_stream_hash.sv
design/shs_check.sv
tb/testbench.sv
